@@ rtl/core/bpss_pkg.sv @@
// Shared widths, types and codes of the Bezout pair shell search core.
`default_nettype none

package bpss_pkg;

    localparam int COEFF_BITS = 16;
    localparam int GCD_BITS   = 15;
    localparam int COEF_BITS  = 17;
    localparam int CNT_BITS   = 33;
    // narrow signed datapath: shell radius, coefficients, quotients
    localparam int NW         = 20;
    // wide signed datapath: products, dividends, test count
    localparam int WW         = 2 * NW;
    localparam int DCNT_W     = $clog2(WW);

    typedef logic signed [COEFF_BITS-1:0] t_coeff;
    typedef logic signed [NW-1:0]         t_nar;
    typedef logic signed [WW-1:0]         t_wide;
    typedef logic        [WW-1:0]         t_uwide;
    typedef logic        [CNT_BITS-1:0]   t_cnt;

    localparam t_nar N_ONE   = t_nar'(1);
    localparam t_nar N_TWO   = t_nar'(2);
    localparam t_nar N_THREE = t_nar'(3);
    localparam t_nar N_FOUR  = t_nar'(4);
    localparam t_nar GCD_MAX = t_nar'((1 << GCD_BITS) - 1);
    localparam t_cnt COUNT_MAX = '1;

    typedef enum logic [0:0] {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    // MUL: opa[NW-1:0] * opb.  DIV: floor(opa / opb), opb > 0, remainder >= 0.
    typedef struct packed {
        logic  start;
        t_op   op;
        t_wide opa;
        t_nar  opb;
    } t_mdu_req;

    typedef struct packed {
        logic  done;
        t_wide quo;
        t_nar  rem;
    } t_mdu_rsp;

endpackage

`default_nettype wire

@@ rtl/core/bpss_mdu.sv @@
// Shared multiply / floor-divide unit: registered multiply, radix-2 restoring divide.
`default_nettype none

module bpss_mdu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpss_pkg::t_mdu_req  i_req,
    output bpss_pkg::t_mdu_rsp  o_rsp
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_DIV  = 3'b010,
        U_FIX  = 3'b100
    } t_ustate;

    t_ustate                       r_state, n_state;
    logic                          r_done;
    logic                          r_neg;
    bpss_pkg::t_uwide              r_mag;
    logic [bpss_pkg::NW-1:0]       r_rem;
    logic [bpss_pkg::NW-1:0]       r_den;
    logic [bpss_pkg::DCNT_W-1:0]   r_cnt;
    bpss_pkg::t_wide               r_quo;
    bpss_pkg::t_nar                r_rrem;

    bpss_pkg::t_nar                w_ma;
    bpss_pkg::t_wide               w_prod;
    bpss_pkg::t_uwide              w_abs;
    logic [bpss_pkg::NW:0]         w_trial;
    logic                          w_bit;
    logic [bpss_pkg::NW-1:0]       w_rem;

    assign w_ma   = i_req.opa[bpss_pkg::NW-1:0];
    assign w_prod = w_ma * i_req.opb;
    assign w_abs  = i_req.opa[bpss_pkg::WW-1] ? bpss_pkg::t_uwide'(-i_req.opa)
                                              : bpss_pkg::t_uwide'(i_req.opa);

    // one quotient bit per cycle
    assign w_trial = {r_rem, r_mag[bpss_pkg::WW-1]} - {1'b0, r_den};
    assign w_bit   = ~w_trial[bpss_pkg::NW];
    assign w_rem   = w_bit ? w_trial[bpss_pkg::NW-1:0]
                           : {r_rem[bpss_pkg::NW-2:0], r_mag[bpss_pkg::WW-1]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: begin
                if (i_req.start && (i_req.op == bpss_pkg::OP_DIV)) begin
                    n_state = U_DIV;
                end
            end
            U_DIV: begin
                if (r_cnt == '0) begin
                    n_state = U_FIX;
                end
            end
            U_FIX:   n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == U_IDLE) && i_req.start && (i_req.op == bpss_pkg::OP_MUL))
                       || (r_state == U_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    if (i_req.op == bpss_pkg::OP_MUL) begin
                        r_quo <= w_prod;
                    end else begin
                        r_neg <= i_req.opa[bpss_pkg::WW-1];
                        r_mag <= w_abs;
                        r_den <= i_req.opb;
                        r_rem <= '0;
                        r_cnt <= bpss_pkg::DCNT_W'(bpss_pkg::WW - 1);
                    end
                end
            end
            U_DIV: begin
                r_rem <= w_rem;
                r_mag <= {r_mag[bpss_pkg::WW-2:0], w_bit};
                r_cnt <= r_cnt - 1'b1;
            end
            U_FIX: begin
                // truncated result to floor form for a negative dividend, passed on as is otherwise
                if (!r_neg) begin
                    r_quo  <= bpss_pkg::t_wide'(r_mag);
                    r_rrem <= r_rem;
                end else if (r_rem == '0) begin
                    r_quo  <= -bpss_pkg::t_wide'(r_mag);
                    r_rrem <= '0;
                end else begin
                    r_quo  <= bpss_pkg::t_wide'(~r_mag);
                    r_rrem <= r_den - r_rem;
                end
            end
            default: begin
                r_rem <= '0;
            end
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rrem;

endmodule

`default_nettype wire

@@ rtl/core/bezout_pair_shell_search_core.sv @@
// Top level of the Bezout pair shell search core: sequencer and result register.
// Work per item: when b is zero no divide is issued; each divide holds the shared unit until
// it is done, so an unsolvable item takes one divide per Euclid step and a solvable one two
// Euclid passes, then a binary search of radius probes of four divides each. Multiplies also
// go through the shared unit.
// Throughput: one item at a time; the input stalls from accept until the result is staged.
// Reset (synchronous, active low) returns the sequencer to idle and drops output valid.
`default_nettype none

module bezout_pair_shell_search_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [bpss_pkg::COEFF_BITS-1:0] i_coeff_a,
    input  logic signed [bpss_pkg::COEFF_BITS-1:0] i_coeff_b,
    input  logic signed [bpss_pkg::COEFF_BITS-1:0] i_target_d,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_solvable,
    output logic        [bpss_pkg::GCD_BITS-1:0]   o_gcd_value,
    output logic signed [bpss_pkg::COEFF_BITS-1:0] o_reduced_a,
    output logic signed [bpss_pkg::COEFF_BITS-1:0] o_reduced_b,
    output logic signed [bpss_pkg::COEF_BITS-1:0]  o_coef_u,
    output logic signed [bpss_pkg::COEF_BITS-1:0]  o_coef_v,
    output logic        [bpss_pkg::CNT_BITS-1:0]   o_test_count
);

    // Flow of one item:
    //   GCD      Euclid on |a|,|b| with the shared divider
    //   CHECK    a, b nonzero and d == gcd, else report unsolvable
    //   RA/RB    a' = a/d, b' = b/d, n = |b'|
    //   AM..U0   modular inverse u0 of a' mod n (extended Euclid)
    //   V0M/V0D  v0 = (1 - a'*u0) / b'
    //   BS..FRET binary search for the smallest even shell radius r holding a
    //            solution u0 + b'k, v0 - a'k; each probe is four floor divides
    //   SEL..VS  pick the first k in scan order and form u, v
    //   SQ/FULL  count the tests: inner shells, full rows, edge-only rows, position
    typedef enum logic [23:0] {
        S_IDLE  = 24'h000001,
        S_GCD   = 24'h000002,
        S_CHECK = 24'h000004,
        S_RA    = 24'h000008,
        S_RB    = 24'h000010,
        S_AM    = 24'h000020,
        S_EU    = 24'h000040,
        S_EUM   = 24'h000080,
        S_U0    = 24'h000100,
        S_V0M   = 24'h000200,
        S_V0D   = 24'h000400,
        S_BSI   = 24'h000800,
        S_BS    = 24'h001000,
        S_F1L   = 24'h002000,
        S_F1H   = 24'h004000,
        S_F2L   = 24'h008000,
        S_F2H   = 24'h010000,
        S_FRET  = 24'h020000,
        S_SEL   = 24'h040000,
        S_US    = 24'h080000,
        S_VS    = 24'h100000,
        S_SQ    = 24'h200000,
        S_FULL  = 24'h400000,
        S_OUT   = 24'h800000
    } t_state;

    function automatic bpss_pkg::t_nar f_abs(input bpss_pkg::t_nar x);
        f_abs = (x < 0) ? -x : x;
    endfunction

    // control
    t_state               r_state, n_state;
    logic                 r_issued;
    logic                 r_out_valid;
    logic                 r_final;

    // item and working registers
    bpss_pkg::t_coeff     r_a, r_b, r_d;
    bpss_pkg::t_nar       r_x, r_y;          // gcd pair, then Euclid remainders
    bpss_pkg::t_nar       r_ra, r_rb, r_n, r_absra;
    bpss_pkg::t_nar       r_os, r_s, r_q;
    bpss_pkg::t_nar       r_u0, r_v0, r_c1, r_c2;
    bpss_pkg::t_nar       r_hlo, r_hhi, r_mid, r_rad;
    bpss_pkg::t_nar       r_lo, r_hi, r_k, r_us, r_vs;
    bpss_pkg::t_wide      r_p;
    logic                 r_solv;
    bpss_pkg::t_cnt       r_cnt;

    // result register
    logic                                  r_o_solv;
    logic        [bpss_pkg::GCD_BITS-1:0]   r_o_gcd;
    logic signed [bpss_pkg::COEFF_BITS-1:0] r_o_ra, r_o_rb;
    logic signed [bpss_pkg::COEF_BITS-1:0]  r_o_u, r_o_v;
    bpss_pkg::t_cnt                        r_o_cnt;

    bpss_pkg::t_mdu_req   w_req;
    bpss_pkg::t_mdu_rsp   w_rsp;
    logic                 w_op_en;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_bad;
    bpss_pkg::t_nar       w_qn;
    bpss_pkg::t_nar       w_ina, w_inb, w_absra, w_m, w_mid;
    bpss_pkg::t_nar       w_2r3, w_2r1, w_rows, w_over, w_full, w_midr, w_pos;
    bpss_pkg::t_wide      w_tot;
    bpss_pkg::t_cnt       w_cnt;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_qn       = bpss_pkg::t_nar'(w_rsp.quo);

    assign w_ina  = bpss_pkg::t_nar'(i_coeff_a);
    assign w_inb  = bpss_pkg::t_nar'(i_coeff_b);
    assign w_absra = f_abs(r_ra);
    assign w_m    = (w_absra > r_n) ? w_absra : r_n;
    assign w_mid  = r_hlo + ((r_hhi - r_hlo) >>> 1);

    assign w_bad = (r_a == '0) || (r_b == '0) || (r_d <= 0)
                   || (bpss_pkg::t_nar'(r_d) != r_x);

    // test count pieces; rows of the final shell scanned before the hit's row
    assign w_2r3  = (r_rad <<< 1) - bpss_pkg::N_THREE;
    assign w_2r1  = (r_rad <<< 1) + bpss_pkg::N_ONE;
    assign w_rows = r_us + r_rad;
    assign w_over = r_us - r_rad + bpss_pkg::N_ONE;
    assign w_full = ((w_rows < bpss_pkg::N_TWO) ? w_rows : bpss_pkg::N_TWO)
                    + ((w_over > 0) ? w_over : '0);
    assign w_midr = w_rows - w_full;
    // hit on an edge row or in the left pair of an inner row, else in the right pair
    assign w_pos  = ((f_abs(r_us) > (r_rad - bpss_pkg::N_TWO))
                     || (r_vs <= (bpss_pkg::N_ONE - r_rad)))
                    ? (r_vs + r_rad + bpss_pkg::N_ONE)
                    : (r_vs - r_rad + bpss_pkg::N_FOUR);
    assign w_tot  = r_p - bpss_pkg::t_wide'(bpss_pkg::N_ONE) + w_rsp.quo
                    + bpss_pkg::t_wide'(w_midr <<< 2) + bpss_pkg::t_wide'(w_pos);
    assign w_cnt  = (w_tot[bpss_pkg::WW-1:bpss_pkg::CNT_BITS] != '0)
                    ? bpss_pkg::COUNT_MAX : w_tot[bpss_pkg::CNT_BITS-1:0];

    // operation issued to the shared unit in each state
    always_comb begin
        w_op_en   = 1'b0;
        w_req.op  = bpss_pkg::OP_DIV;
        w_req.opa = '0;
        w_req.opb = '0;
        case (r_state)
            S_GCD: begin
                w_op_en   = (r_y != '0);
                w_req.opa = bpss_pkg::t_wide'(r_x);
                w_req.opb = r_y;
            end
            S_RA: begin
                w_op_en   = 1'b1;
                w_req.opa = bpss_pkg::t_wide'(r_a);
                w_req.opb = bpss_pkg::t_nar'(r_d);
            end
            S_RB: begin
                w_op_en   = 1'b1;
                w_req.opa = bpss_pkg::t_wide'(r_b);
                w_req.opb = bpss_pkg::t_nar'(r_d);
            end
            S_AM: begin
                w_op_en   = (r_n != bpss_pkg::N_ONE);
                w_req.opa = bpss_pkg::t_wide'(r_ra);
                w_req.opb = r_n;
            end
            S_EU: begin
                w_op_en   = (r_y != '0);
                w_req.opa = bpss_pkg::t_wide'(r_x);
                w_req.opb = r_y;
            end
            S_EUM: begin
                w_op_en   = 1'b1;
                w_req.op  = bpss_pkg::OP_MUL;
                w_req.opa = bpss_pkg::t_wide'(r_q);
                w_req.opb = r_s;
            end
            S_U0: begin
                w_op_en   = 1'b1;
                w_req.opa = bpss_pkg::t_wide'(r_os);
                w_req.opb = r_n;
            end
            S_V0M: begin
                w_op_en   = 1'b1;
                w_req.op  = bpss_pkg::OP_MUL;
                w_req.opa = bpss_pkg::t_wide'(r_ra);
                w_req.opb = r_u0;
            end
            S_V0D: begin
                // divide by |b'|, sign folded into the dividend
                w_op_en   = 1'b1;
                w_req.opa = (r_rb < 0) ? (r_p - bpss_pkg::t_wide'(bpss_pkg::N_ONE))
                                       : (bpss_pkg::t_wide'(bpss_pkg::N_ONE) - r_p);
                w_req.opb = r_n;
            end
            S_F1L: begin
                w_op_en   = 1'b1;
                w_req.opa = bpss_pkg::t_wide'(r_rad + r_c1);
                w_req.opb = r_n;
            end
            S_F1H: begin
                w_op_en   = 1'b1;
                w_req.opa = bpss_pkg::t_wide'(r_rad - r_c1);
                w_req.opb = r_n;
            end
            S_F2L: begin
                w_op_en   = 1'b1;
                w_req.opa = bpss_pkg::t_wide'(r_rad + r_c2);
                w_req.opb = r_absra;
            end
            S_F2H: begin
                w_op_en   = 1'b1;
                w_req.opa = bpss_pkg::t_wide'(r_rad - r_c2);
                w_req.opb = r_absra;
            end
            S_US: begin
                w_op_en   = 1'b1;
                w_req.op  = bpss_pkg::OP_MUL;
                w_req.opa = bpss_pkg::t_wide'(r_rb);
                w_req.opb = r_k;
            end
            S_VS: begin
                w_op_en   = 1'b1;
                w_req.op  = bpss_pkg::OP_MUL;
                w_req.opa = bpss_pkg::t_wide'(r_ra);
                w_req.opb = r_k;
            end
            S_SQ: begin
                w_op_en   = 1'b1;
                w_req.op  = bpss_pkg::OP_MUL;
                w_req.opa = bpss_pkg::t_wide'(w_2r3);
                w_req.opb = w_2r3;
            end
            S_FULL: begin
                w_op_en   = 1'b1;
                w_req.op  = bpss_pkg::OP_MUL;
                w_req.opa = bpss_pkg::t_wide'(w_full);
                w_req.opb = w_2r1;
            end
            default: begin
                w_op_en = 1'b0;
            end
        endcase
        w_req.start = w_op_en && !r_issued;
    end

    bpss_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_GCD;
            S_GCD:   if (r_y == '0) n_state = S_CHECK;
            S_CHECK: n_state = w_bad ? S_OUT : S_RA;
            S_RA:    if (w_rsp.done) n_state = S_RB;
            S_RB:    if (w_rsp.done) n_state = S_AM;
            S_AM: begin
                if (r_n == bpss_pkg::N_ONE) begin
                    n_state = S_V0M;
                end else if (w_rsp.done) begin
                    n_state = S_EU;
                end
            end
            S_EU: begin
                if (r_y == '0) begin
                    n_state = S_U0;
                end else if (w_rsp.done) begin
                    n_state = S_EUM;
                end
            end
            S_EUM:   if (w_rsp.done) n_state = S_EU;
            S_U0:    if (w_rsp.done) n_state = S_V0M;
            S_V0M:   if (w_rsp.done) n_state = S_V0D;
            S_V0D:   if (w_rsp.done) n_state = S_BSI;
            S_BSI:   n_state = S_BS;
            S_BS:    n_state = S_F1L;
            S_F1L:   if (w_rsp.done) n_state = S_F1H;
            S_F1H:   if (w_rsp.done) n_state = S_F2L;
            S_F2L:   if (w_rsp.done) n_state = S_F2H;
            S_F2H:   if (w_rsp.done) n_state = S_FRET;
            S_FRET:  n_state = r_final ? S_SEL : S_BS;
            S_SEL:   n_state = S_US;
            S_US:    if (w_rsp.done) n_state = S_VS;
            S_VS:    if (w_rsp.done) n_state = S_SQ;
            S_SQ:    if (w_rsp.done) n_state = S_FULL;
            S_FULL:  if (w_rsp.done) n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_req.start) begin
                r_issued <= 1'b1;
            end else if (w_rsp.done) begin
                r_issued <= 1'b0;
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_BS) begin
                r_final <= !(r_hlo < r_hhi);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_a <= i_coeff_a;
                    r_b <= i_coeff_b;
                    r_d <= i_target_d;
                    r_x <= f_abs(w_ina);
                    r_y <= f_abs(w_inb);
                end
            end
            S_GCD: begin
                if (w_rsp.done) begin
                    r_x <= r_y;
                    r_y <= w_rsp.rem;
                end
            end
            S_CHECK: r_solv <= !w_bad;
            S_RA: if (w_rsp.done) r_ra <= w_qn;
            S_RB: begin
                if (w_rsp.done) begin
                    r_rb <= w_qn;
                    r_n  <= f_abs(w_qn);
                end
            end
            S_AM: begin
                if (r_n == bpss_pkg::N_ONE) begin
                    r_u0 <= '0;
                end else if (w_rsp.done) begin
                    r_x  <= w_rsp.rem;
                    r_y  <= r_n;
                    r_os <= bpss_pkg::N_ONE;
                    r_s  <= '0;
                end
            end
            S_EU: begin
                if (w_rsp.done) begin
                    r_q <= w_qn;
                    r_x <= r_y;
                    r_y <= w_rsp.rem;
                end
            end
            S_EUM: begin
                if (w_rsp.done) begin
                    r_os <= r_s;
                    r_s  <= r_os - w_qn;
                end
            end
            S_U0:  if (w_rsp.done) r_u0 <= w_rsp.rem;
            S_V0M: if (w_rsp.done) r_p <= w_rsp.quo;
            S_V0D: if (w_rsp.done) r_v0 <= w_qn;
            S_BSI: begin
                r_absra <= w_absra;
                r_hlo   <= bpss_pkg::N_ONE;
                r_hhi   <= (w_m >>> 1) + bpss_pkg::N_ONE;
                r_c1    <= (r_rb < 0) ? -r_u0 : r_u0;
                r_c2    <= (r_ra > 0) ? -r_v0 : r_v0;
            end
            S_BS: begin
                r_mid <= w_mid;
                r_rad <= (r_hlo < r_hhi) ? (w_mid <<< 1) : (r_hlo <<< 1);
            end
            S_F1L: if (w_rsp.done) r_lo <= -w_qn;
            S_F1H: if (w_rsp.done) r_hi <= w_qn;
            S_F2L: if (w_rsp.done && (-w_qn > r_lo)) r_lo <= -w_qn;
            S_F2H: if (w_rsp.done && (w_qn < r_hi)) r_hi <= w_qn;
            S_FRET: begin
                if (!r_final) begin
                    if (r_lo <= r_hi) begin
                        r_hhi <= r_mid;
                    end else begin
                        r_hlo <= r_mid + bpss_pkg::N_ONE;
                    end
                end
            end
            S_SEL: r_k <= (r_rb > 0) ? r_lo : r_hi;
            S_US:  if (w_rsp.done) r_us <= r_u0 + w_qn;
            S_VS:  if (w_rsp.done) r_vs <= r_v0 - w_qn;
            S_SQ:  if (w_rsp.done) r_p <= w_rsp.quo;
            S_FULL: if (w_rsp.done) r_cnt <= w_cnt;
            S_OUT: begin
                if (w_out_free) begin
                    r_o_solv <= r_solv;
                    // r_x is reused by the inverse search; a solvable item has gcd == d
                    r_o_gcd  <= r_solv ? r_d[bpss_pkg::GCD_BITS-1:0]
                              : (r_x > bpss_pkg::GCD_MAX)
                                ? bpss_pkg::GCD_MAX[bpss_pkg::GCD_BITS-1:0]
                                : r_x[bpss_pkg::GCD_BITS-1:0];
                    r_o_ra   <= r_solv ? r_ra[bpss_pkg::COEFF_BITS-1:0] : '0;
                    r_o_rb   <= r_solv ? r_rb[bpss_pkg::COEFF_BITS-1:0] : '0;
                    r_o_u    <= r_solv ? r_us[bpss_pkg::COEF_BITS-1:0] : '0;
                    r_o_v    <= r_solv ? r_vs[bpss_pkg::COEF_BITS-1:0] : '0;
                    r_o_cnt  <= r_solv ? r_cnt : '0;
                end
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_solvable   = r_o_solv;
    assign o_gcd_value  = r_o_gcd;
    assign o_reduced_a  = r_o_ra;
    assign o_reduced_b  = r_o_rb;
    assign o_coef_u     = r_o_u;
    assign o_coef_v     = r_o_v;
    assign o_test_count = r_o_cnt;

endmodule

`default_nettype wire

@@ rtl/core/bpss_checker.sv @@
// Port-level checks of the Bezout pair shell search core, bound to the top level.
`default_nettype none

module bpss_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic                                  o_solvable,
    input logic signed [bpss_pkg::COEFF_BITS-1:0] o_reduced_a,
    input logic signed [bpss_pkg::COEFF_BITS-1:0] o_reduced_b,
    input logic signed [bpss_pkg::COEF_BITS-1:0]  o_coef_u,
    input logic signed [bpss_pkg::COEF_BITS-1:0]  o_coef_v,
    input logic        [bpss_pkg::CNT_BITS-1:0]   o_test_count
);

    logic signed [33:0] w_dot;

    assign w_dot = o_reduced_a * o_coef_u + o_reduced_b * o_coef_v;

    // reset leaves the block idle with nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("not idle after reset");

    // an accepted beat keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input ready right after accept");

    // a found pair satisfies a'u + b'v = 1 and was counted
    a_pair_solves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_solvable) |-> ((w_dot == 34'sd1) && (o_test_count != '0)))
        else $error("reported pair does not solve the reduced equation");

    // unsolvable results carry no pair and no count
    a_unsolvable_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_solvable) |->
        ((o_coef_u == '0) && (o_coef_v == '0) && (o_test_count == '0)
         && (o_reduced_a == '0) && (o_reduced_b == '0)))
        else $error("unsolvable result with nonzero fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_test_count)
                                          && $stable(o_coef_u)))
        else $error("stalled output beat changed");

endmodule

bind bezout_pair_shell_search_core bpss_checker u_bpss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_solvable   (o_solvable),
    .o_reduced_a  (o_reduced_a),
    .o_reduced_b  (o_reduced_b),
    .o_coef_u     (o_coef_u),
    .o_coef_v     (o_coef_v),
    .o_test_count (o_test_count)
);

`default_nettype wire
